[rtl/grid_shadowcast_visibility_core_defines.svh]
// ----------------------------------------------------------------------------
// grid shadowcast visibility: assertion macros
// Concurrent assertion wrappers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef GRID_SHADOWCAST_VISIBILITY_CORE_DEFINES_SVH
`define GRID_SHADOWCAST_VISIBILITY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define GSV_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GSV_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSV_ASSERT(name, clk, rst, prop, msg)
`define GSV_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[rtl/gsv_pkg.sv]
// ----------------------------------------------------------------------------
// gsv_pkg
// Field widths, operation codes, register indexes and octant transforms.
// ----------------------------------------------------------------------------
`default_nettype none

package gsv_pkg;

   localparam int OP_W    = 2;
   localparam int COORD_W = 7;
   localparam int TILE_W  = 4;
   localparam int RAD_IN_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MASK_W  = 16;

   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_RECOMP = 2'd2;
   localparam logic [OP_W-1:0] OP_FILL   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSP     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL       = 2'd3;

   localparam logic [COORD_W-1:0] RST_MAP_WIDTH  = 7'd64;
   localparam logic [COORD_W-1:0] RST_MAP_HEIGHT = 7'd64;
   localparam logic [MASK_W-1:0]  RST_TRANSP     = 16'd1;
   localparam logic [TILE_W-1:0]  RST_WALL       = 4'd1;

   // flag word: bit 1 seen, bit 0 visible
   localparam int FLAG_VIS  = 0;
   localparam int FLAG_SEEN = 1;

   localparam logic signed [1:0] OCT_XX [8] = '{2'sd1, 2'sd0, 2'sd0, -2'sd1,
                                               -2'sd1, 2'sd0, 2'sd0, 2'sd1};
   localparam logic signed [1:0] OCT_XY [8] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0,
                                               2'sd0, -2'sd1, 2'sd1, 2'sd0};
   localparam logic signed [1:0] OCT_YX [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd0,
                                               2'sd0, -2'sd1, -2'sd1, 2'sd0};
   localparam logic signed [1:0] OCT_YY [8] = '{2'sd1, 2'sd0, 2'sd0, 2'sd1,
                                               -2'sd1, 2'sd0, 2'sd0, -2'sd1};

endpackage

`default_nettype wire

[rtl/gsv_req_if.sv]
// ----------------------------------------------------------------------------
// gsv_req_if
// Request channel: operation, coordinates, tile type and sight radius.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsv_req_if;
   logic                           valid;
   logic                           ready;
   logic [gsv_pkg::OP_W-1:0]       operation;
   logic [gsv_pkg::COORD_W-1:0]    x_coord;
   logic [gsv_pkg::COORD_W-1:0]    y_coord;
   logic [gsv_pkg::TILE_W-1:0]     tile_value;
   logic [gsv_pkg::RAD_IN_W-1:0]   view_radius;

   modport source (output valid, operation, x_coord, y_coord, tile_value, view_radius,
                   input ready);
   modport sink   (input valid, operation, x_coord, y_coord, tile_value, view_radius,
                   output ready);
endinterface

`default_nettype wire

[rtl/gsv_rsp_if.sv]
// ----------------------------------------------------------------------------
// gsv_rsp_if
// Response channel: tile type, visible and seen bits, bounds flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gsv_pkg::TILE_W-1:0] tile_out;
   logic                       visible_out;
   logic                       seen_out;
   logic                       in_bounds;

   modport source (output valid, tile_out, visible_out, seen_out, in_bounds, input ready);
   modport sink   (input valid, tile_out, visible_out, seen_out, in_bounds, output ready);
endinterface

`default_nettype wire

[rtl/grid_shadowcast_visibility_core.sv]
// ----------------------------------------------------------------------------
// grid_shadowcast_visibility_core
// Tile grid with visible/seen bits and eight-octant shadowcast field of view.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tile and flag memories to zero, one cell a
// cycle, with req ready low. One request is worked at a time. A tile read or
// write passes through accept, memory read and response register. A fill sweeps
// every cell once. A recompute first clears the visible bits with a
// read-modify-write sweep, then walks the eight octants: a setup step for each
// octant, the scan steps, an opacity step for every cell whose tile must be
// fetched from the tile memory, and a reload step per stack pop, so its length
// follows the radius and the walls around the viewer. The response is held in
// an output register, so a new request is taken while the previous response
// waits.
`default_nettype none

`include "grid_shadowcast_visibility_core_defines.svh"

module grid_shadowcast_visibility_core #(
   parameter int MAX_SIDE   = 64,
   parameter int MAX_RADIUS = 32,
   parameter int TILE_TYPES = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   gsv_req_if.sink                                req_if,
   gsv_rsp_if.source                              rsp_if,
   input  wire logic                              csr_wr_en,
   input  wire logic [gsv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [gsv_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int CELLS  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int RW     = $clog2(MAX_RADIUS + 2);
   localparam int CLW    = RW + 1;
   localparam int SL_W   = $clog2(2 * MAX_RADIUS + 4) + 1;
   localparam int AX_W   = ((RW > gsv_pkg::COORD_W) ? RW : gsv_pkg::COORD_W) + 2;
   localparam int STK    = MAX_RADIUS + 1;
   localparam int SPW    = $clog2(STK + 1);
   localparam int SIW    = $clog2(STK);
   localparam int DW     = 2 * RW + 1;

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_FILL  = 4'd2;
   localparam logic [3:0] ST_VCLR  = 4'd3;
   localparam logic [3:0] ST_VEND  = 4'd4;
   localparam logic [3:0] ST_OCT   = 4'd5;
   localparam logic [3:0] ST_FRAME = 4'd6;
   localparam logic [3:0] ST_OPQ   = 4'd7;
   localparam logic [3:0] ST_POPW  = 4'd8;
   localparam logic [3:0] ST_RD    = 4'd9;
   localparam logic [3:0] ST_DATA  = 4'd10;

   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [SPW-1:0]    SP_MAX    = SPW'(STK);

   typedef struct packed {
      logic [RW-1:0]            row;
      logic signed [CLW-1:0]    col;
      logic signed [SL_W-1:0]   sn;
      logic signed [SL_W-1:0]   sd;
      logic signed [SL_W-1:0]   en;
      logic signed [SL_W-1:0]   ed;
      logic signed [SL_W-1:0]   nn;
      logic signed [SL_W-1:0]   nd;
      logic                     blocked;
      logic                     started;
   } frame_type;

   // a/b < c/d with b, d > 0
   function automatic logic slope_lt(input logic signed [SL_W-1:0] a,
                                     input logic signed [SL_W-1:0] b,
                                     input logic signed [SL_W-1:0] c,
                                     input logic signed [SL_W-1:0] d);
      logic signed [2*SL_W-1:0] p;
      logic signed [2*SL_W-1:0] q;
      p = (2*SL_W)'(a) * (2*SL_W)'(d);
      q = (2*SL_W)'(c) * (2*SL_W)'(b);
      return p < q;
   endfunction

   function automatic logic in_map(input logic signed [AX_W-1:0] ax,
                                   input logic signed [AX_W-1:0] ay,
                                   input logic signed [AX_W-1:0] w,
                                   input logic signed [AX_W-1:0] h);
      return !ax[AX_W-1] && !ay[AX_W-1] && (ax < w) && (ay < h);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_index(input logic [AX_W-1:0] ax,
                                                    input logic [AX_W-1:0] ay);
      logic [31:0] s;
      s = 32'(ay) * MAX_SIDE + 32'(ax);
      return s[ADDR_W-1:0];
   endfunction

   // memories
   logic [gsv_pkg::TILE_W-1:0] tile_mem [CELLS];
   logic [1:0]                 flag_mem [CELLS];
   frame_type                  stk_mem  [STK];

   logic                       tile_we;
   logic [ADDR_W-1:0]          tile_wa, tile_ra;
   logic [gsv_pkg::TILE_W-1:0] tile_wd, tile_rd_ff;
   logic                       flag_we;
   logic [ADDR_W-1:0]          flag_wa, flag_ra;
   logic [1:0]                 flag_wd, flag_rd_ff;
   logic                       stk_we;
   logic [SIW-1:0]             stk_wa, stk_ra;
   frame_type                  stk_rd_ff;

   // configuration
   logic [gsv_pkg::COORD_W-1:0] width_ff, height_ff;
   logic [gsv_pkg::MASK_W-1:0]  mask_ff;
   logic [gsv_pkg::TILE_W-1:0]  wall_ff;

   // control and work registers
   logic [3:0]                  state_ff, state_in;
   logic [ADDR_W-1:0]           cnt_ff, cnt_in;
   logic [2:0]                  oct_ff, oct_in;
   logic [SPW-1:0]              sp_ff, sp_in;
   logic                        vpend_ff, vpend_in;
   logic [ADDR_W-1:0]           vaddr_ff, vaddr_in;
   logic [gsv_pkg::OP_W-1:0]    op_ff, op_in;
   logic [gsv_pkg::COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [gsv_pkg::TILE_W-1:0]  tv_ff, tv_in;
   logic [RW-1:0]               rad_ff, rad_in;
   frame_type                   cur_ff, cur_in;
   logic signed [SL_W-1:0]      ln_ff, ln_in, ld_ff, ld_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [RW-1:0]               ci_ff, ci_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gsv_pkg::TILE_W-1:0]  rsp_tile_ff, rsp_tile_in;
   logic                        rsp_vis_ff, rsp_vis_in;
   logic                        rsp_seen_ff, rsp_seen_in;
   logic                        rsp_inb_ff, rsp_inb_in;

   // derived values
   logic signed [AX_W-1:0]      ew, eh;
   logic signed [AX_W-1:0]      x_s, y_s, rqx_s, rqy_s, c_ax, i_ax, ax, ay;
   logic signed [SL_W-1:0]      c_s, i_s, ln, ld, rn, rd;
   logic [RW-1:0]               c_u;
   logic [DW-1:0]               c_sq, i_sq, r_sq;
   logic [DW:0]                 d_sum;
   logic                        org_in, cell_in, req_in, dist_ok, opq;
   logic                        lt_start, lt_rs, lt_le;
   logic [ADDR_W-1:0]           org_addr, cell_addr, req_addr;
   logic                        pop;
   frame_type                   upd;
   logic                        push;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.tile_out    = rsp_tile_ff;
   assign rsp_if.visible_out = rsp_vis_ff;
   assign rsp_if.seen_out    = rsp_seen_ff;
   assign rsp_if.in_bounds   = rsp_inb_ff;

   always_comb begin
      ew = (32'(width_ff) > MAX_SIDE) ? AX_W'(MAX_SIDE) : AX_W'(width_ff);
      eh = (32'(height_ff) > MAX_SIDE) ? AX_W'(MAX_SIDE) : AX_W'(height_ff);
      x_s   = AX_W'(x_ff);
      y_s   = AX_W'(y_ff);
      rqx_s = AX_W'(req_if.x_coord);
      rqy_s = AX_W'(req_if.y_coord);
      c_ax  = AX_W'(cur_ff.col);
      i_ax  = AX_W'(cur_ff.row);
      ax = x_s - c_ax * gsv_pkg::OCT_XX[oct_ff] - i_ax * gsv_pkg::OCT_XY[oct_ff];
      ay = y_s - c_ax * gsv_pkg::OCT_YX[oct_ff] - i_ax * gsv_pkg::OCT_YY[oct_ff];
      c_s = SL_W'(cur_ff.col);
      i_s = SL_W'(cur_ff.row);
      ln = (c_s <<< 1) + SL_W'(1);
      ld = (i_s <<< 1) - SL_W'(1);
      rn = (c_s <<< 1) - SL_W'(1);
      rd = (i_s <<< 1) + SL_W'(1);
      c_u = cur_ff.col[RW-1:0];
      c_sq = DW'(c_u) * DW'(c_u);
      i_sq = DW'(cur_ff.row) * DW'(cur_ff.row);
      r_sq = DW'(rad_ff) * DW'(rad_ff);
      d_sum = (DW + 1)'(c_sq) + (DW + 1)'(i_sq);
      dist_ok = d_sum < (DW + 1)'(r_sq);
      org_in  = in_map(x_s, y_s, ew, eh);
      cell_in = in_map(ax, ay, ew, eh);
      req_in  = in_map(rqx_s, rqy_s, ew, eh);
      org_addr  = cell_index(x_s, y_s);
      cell_addr = cell_index(ax, ay);
      req_addr  = cell_index(rqx_s, rqy_s);
      lt_start = slope_lt(cur_ff.sn, cur_ff.sd, cur_ff.en, cur_ff.ed);
      lt_rs    = slope_lt(cur_ff.sn, cur_ff.sd, rn, rd);
      lt_le    = slope_lt(ln, ld, cur_ff.en, cur_ff.ed);
      // types at or above the type count never let sight through
      opq = (5'(tile_rd_ff) >= 5'(TILE_TYPES)) || !mask_ff[tile_rd_ff];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      oct_in   = oct_ff;
      sp_in    = sp_ff;
      vpend_in = 1'b0;
      vaddr_in = cnt_ff;
      op_in    = op_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      tv_in    = tv_ff;
      rad_in   = rad_ff;
      cur_in   = cur_ff;
      ln_in    = ln_ff;
      ld_in    = ld_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      ci_in    = ci_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_tile_in  = rsp_tile_ff;
      rsp_vis_in   = rsp_vis_ff;
      rsp_seen_in  = rsp_seen_ff;
      rsp_inb_in   = rsp_inb_ff;
      tile_we = 1'b0;
      tile_wa = cnt_ff;
      tile_wd = tv_ff;
      tile_ra = org_addr;
      flag_we = 1'b0;
      flag_wa = cnt_ff;
      flag_wd = 2'b00;
      flag_ra = org_addr;
      stk_we  = 1'b0;
      stk_wa  = sp_ff[SIW-1:0];
      stk_ra  = SIW'(sp_ff - SPW'(1));
      pop     = 1'b0;
      push    = 1'b0;
      upd     = cur_ff;

      // second half of the visibility clear: write back with visible dropped
      if (vpend_ff) begin
         flag_we = 1'b1;
         flag_wa = vaddr_ff;
         flag_wd = {flag_rd_ff[gsv_pkg::FLAG_SEEN], 1'b0};
      end

      unique case (state_ff)
         ST_CLR: begin
            tile_we = 1'b1;
            tile_wd = '0;
            flag_we = 1'b1;
            cnt_in  = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (req_if.valid) begin
               op_in  = req_if.operation;
               x_in   = req_if.x_coord;
               y_in   = req_if.y_coord;
               tv_in  = req_if.tile_value;
               rad_in = (32'(req_if.view_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS)
                                                               : RW'(req_if.view_radius);
               unique case (req_if.operation)
                  gsv_pkg::OP_WRITE: begin
                     tile_we  = req_in;
                     tile_wa  = req_addr;
                     tile_wd  = req_if.tile_value;
                     state_in = ST_RD;
                  end
                  gsv_pkg::OP_READ:   state_in = ST_RD;
                  gsv_pkg::OP_RECOMP: state_in = ST_VCLR;
                  gsv_pkg::OP_FILL:   state_in = ST_FILL;
                  default:            state_in = ST_RD;
               endcase
            end
         end
         ST_FILL: begin
            tile_we = 1'b1;
            flag_we = 1'b1;
            flag_wd = 2'b00;
            cnt_in  = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_RD;
            end
         end
         ST_VCLR: begin
            flag_ra  = cnt_ff;
            vpend_in = 1'b1;
            vaddr_in = cnt_ff;
            cnt_in   = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_VEND;
            end
         end
         ST_VEND: begin
            oct_in   = '0;
            state_in = ST_OCT;
         end
         ST_OCT: begin
            sp_in  = '0;
            cur_in = '0;
            cur_in.row = RW'(1);
            cur_in.sn  = SL_W'(1);
            cur_in.sd  = SL_W'(1);
            cur_in.en  = '0;
            cur_in.ed  = SL_W'(1);
            state_in = ST_FRAME;
         end
         ST_FRAME: begin
            if (!cur_ff.started) begin
               cur_in.started = 1'b1;
               if (lt_start) begin
                  pop = 1'b1;
               end else begin
                  flag_we = org_in;
                  flag_wa = org_addr;
                  flag_wd = 2'b11;
                  cur_in.col     = CLW'(cur_ff.row);
                  cur_in.blocked = 1'b0;
                  cur_in.nn      = cur_ff.sn;
                  cur_in.nd      = cur_ff.sd;
               end
            end else if (cur_ff.row > rad_ff) begin
               pop = 1'b1;
            end else if (cur_ff.col[CLW-1]) begin
               if (cur_ff.blocked) begin
                  pop = 1'b1;
               end else begin
                  cur_in.row = cur_ff.row + RW'(1);
                  cur_in.col = CLW'(cur_ff.row + RW'(1));
               end
            end else begin
               cur_in.col = cur_ff.col - CLW'(1);
               if (lt_rs) begin
                  cur_in.col = cur_ff.col - CLW'(1);
               end else if (lt_le) begin
                  cur_in.col = -CLW'(1);
               end else if (cell_in) begin
                  flag_we  = dist_ok;
                  flag_wa  = cell_addr;
                  flag_wd  = 2'b11;
                  tile_ra  = cell_addr;
                  ln_in    = ln;
                  ld_in    = ld;
                  rn_in    = rn;
                  rd_in    = rd;
                  ci_in    = cur_ff.row;
                  state_in = ST_OPQ;
               end
            end
            if (pop) begin
               if (sp_ff == '0) begin
                  if (oct_ff == 3'd7) begin
                     state_in = ST_RD;
                  end else begin
                     oct_in   = oct_ff + 3'd1;
                     state_in = ST_OCT;
                  end
               end else begin
                  sp_in    = sp_ff - SPW'(1);
                  state_in = ST_POPW;
               end
            end
         end
         ST_OPQ: begin
            if (cur_ff.blocked) begin
               if (opq) begin
                  upd.nn = rn_ff;
                  upd.nd = rd_ff;
               end else begin
                  upd.blocked = 1'b0;
                  upd.sn = cur_ff.nn;
                  upd.sd = cur_ff.nd;
               end
            end else if (opq) begin
               upd.blocked = 1'b1;
               upd.nn = rn_ff;
               upd.nd = rd_ff;
               push = (ci_ff < rad_ff);
            end
            cur_in   = upd;
            state_in = ST_FRAME;
            // child frame covers the lit span above the new wall
            if (push) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + SPW'(1);
               cur_in = '0;
               cur_in.row = ci_ff + RW'(1);
               cur_in.sn  = cur_ff.sn;
               cur_in.sd  = cur_ff.sd;
               cur_in.en  = ln_ff;
               cur_in.ed  = ld_ff;
            end
         end
         ST_POPW: begin
            cur_in   = stk_rd_ff;
            state_in = ST_FRAME;
         end
         ST_RD: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_inb_in   = org_in;
               rsp_tile_in  = org_in ? tile_rd_ff : wall_ff;
               rsp_vis_in   = org_in && flag_rd_ff[gsv_pkg::FLAG_VIS];
               rsp_seen_in  = org_in && flag_rd_ff[gsv_pkg::FLAG_SEEN];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (tile_we) begin
         tile_mem[tile_wa] <= tile_wd;
      end
      tile_rd_ff <= tile_mem[tile_ra];
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flag_rd_ff <= flag_mem[flag_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= upd;
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         oct_ff       <= '0;
         sp_ff        <= '0;
         vpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= gsv_pkg::RST_MAP_WIDTH;
         height_ff    <= gsv_pkg::RST_MAP_HEIGHT;
         mask_ff      <= gsv_pkg::RST_TRANSP;
         wall_ff      <= gsv_pkg::RST_WALL;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         oct_ff       <= oct_in;
         sp_ff        <= sp_in;
         vpend_ff     <= vpend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               gsv_pkg::CSR_MAP_WIDTH:  width_ff  <= csr_wr_data[gsv_pkg::COORD_W-1:0];
               gsv_pkg::CSR_MAP_HEIGHT: height_ff <= csr_wr_data[gsv_pkg::COORD_W-1:0];
               gsv_pkg::CSR_TRANSP:     mask_ff   <= csr_wr_data[gsv_pkg::MASK_W-1:0];
               gsv_pkg::CSR_WALL:       wall_ff   <= csr_wr_data[gsv_pkg::TILE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      vaddr_ff    <= vaddr_in;
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      tv_ff       <= tv_in;
      rad_ff      <= rad_in;
      cur_ff      <= cur_in;
      ln_ff       <= ln_in;
      ld_ff       <= ld_in;
      rn_ff       <= rn_in;
      rd_ff       <= rd_in;
      ci_ff       <= ci_in;
      rsp_tile_ff <= rsp_tile_in;
      rsp_vis_ff  <= rsp_vis_in;
      rsp_seen_ff <= rsp_seen_in;
      rsp_inb_ff  <= rsp_inb_in;
   end

   `GSV_ASSERT_ALWAYS(a_reset_sweep, clock, reset |=> (state_ff == ST_CLR) && !rsp_valid_ff, "reset must start the clearing sweep with no response pending")
   `GSV_ASSERT(a_stack_bound, clock, reset, sp_ff <= SP_MAX, "scan stack pointer past its depth")
   `GSV_ASSERT(a_opq_after_frame, clock, reset, (state_ff == ST_OPQ) |-> ($past(state_ff) == ST_FRAME), "opacity step without a cell fetch")
   `GSV_ASSERT(a_busy_after_accept, clock, reset, (req_if.valid && req_if.ready) |=> (state_ff != ST_IDLE), "accepted beat left the block idle")
   `GSV_ASSERT(a_op_latched, clock, reset, (state_ff == ST_FILL) |-> (op_ff == gsv_pkg::OP_FILL), "fill sweep without a fill request")

endmodule

`default_nettype wire

[test/grid_shadowcast_visibility_core_tb.sv]
// ----------------------------------------------------------------------------
// grid_shadowcast_visibility_core_tb
// Drives tile reads, writes, fills and field-of-view recomputes through the
// request channel with random gaps and response stalls. A behavioral copy of
// the grid and its shadowcast scan predicts every response beat, which is
// checked field by field in order. Map size, transparency and wall type are
// reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_shadowcast_visibility_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE     = 64;
   localparam int RAD_MAX  = 32;
   localparam int CELL_NUM = SIDE * SIDE;
   localparam int STALL_LIMIT = 200000;

   typedef struct packed {
      logic [gsv_pkg::OP_W-1:0]     op;
      logic [gsv_pkg::COORD_W-1:0]  x;
      logic [gsv_pkg::COORD_W-1:0]  y;
      logic [gsv_pkg::TILE_W-1:0]   tv;
      logic [gsv_pkg::RAD_IN_W-1:0] rad;
   } cmd_type;

   typedef struct packed {
      logic [gsv_pkg::TILE_W-1:0] tile;
      logic                       vis;
      logic                       seen;
      logic                       inb;
   } cell_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [gsv_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gsv_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   gsv_req_if req ();
   gsv_rsp_if rsp ();

   grid_shadowcast_visibility_core DUT (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // grid mirror
   logic [gsv_pkg::TILE_W-1:0] grid_tile [CELL_NUM];
   bit                grid_vis  [CELL_NUM];
   bit                grid_seen [CELL_NUM];
   int unsigned mir_width = 64, mir_height = 64, mir_wall = 1;
   logic [15:0] mir_transp = 16'd1;

   // scan frames
   int  fr_row [RAD_MAX+1], fr_col [RAD_MAX+1];
   int  fr_sn [RAD_MAX+1], fr_sd [RAD_MAX+1], fr_en [RAD_MAX+1], fr_ed [RAD_MAX+1];
   int  fr_nn [RAD_MAX+1], fr_nd [RAD_MAX+1];
   bit  fr_blk [RAD_MAX+1], fr_go [RAD_MAX+1];
   int  depth;

   cmd_type      pending_cmds [$];
   cell_rsp_type predicted_rsp [$];
   int        errors = 0;
   bit        calm = 0;

   function automatic int map_w();
      return (mir_width > SIDE) ? SIDE : mir_width;
   endfunction

   function automatic int map_h();
      return (mir_height > SIDE) ? SIDE : mir_height;
   endfunction

   function automatic bit on_map(int x, int y);
      return x >= 0 && y >= 0 && x < map_w() && y < map_h();
   endfunction

   task automatic light_cell(int x, int y);
      if (on_map(x, y)) begin
         grid_vis[y*SIDE+x] = 1;
         grid_seen[y*SIDE+x] = 1;
      end
   endtask

   task automatic push_scan(int row, int sn, int sd, int en, int ed);
      if (depth < RAD_MAX + 1) begin
         fr_row[depth] = row; fr_col[depth] = 0;
         fr_sn[depth] = sn; fr_sd[depth] = sd; fr_en[depth] = en; fr_ed[depth] = ed;
         fr_nn[depth] = 0; fr_nd[depth] = 0; fr_blk[depth] = 0; fr_go[depth] = 0;
         depth++;
      end
   endtask

   task automatic cast_octant(int ox, int oy, int r, int oct);
      int xx, xy, yx, yy, f, i, c, ln, ld, rn, rd, ax, ay;
      bit spawned, finished, op;
      xx = gsv_pkg::OCT_XX[oct]; xy = gsv_pkg::OCT_XY[oct];
      yx = gsv_pkg::OCT_YX[oct]; yy = gsv_pkg::OCT_YY[oct];
      depth = 0;
      push_scan(1, 1, 1, 0, 1);
      while (depth > 0) begin
         f = depth - 1;
         spawned = 0;
         finished = 0;
         if (!fr_go[f]) begin
            fr_go[f] = 1;
            if (fr_sn[f] * fr_ed[f] < fr_en[f] * fr_sd[f]) begin
               depth--;
               continue;
            end
            light_cell(ox, oy);
            fr_col[f] = fr_row[f];
            fr_blk[f] = 0;
            fr_nn[f] = fr_sn[f]; fr_nd[f] = fr_sd[f];
         end
         while (!spawned && !finished) begin
            if (fr_row[f] > r) begin
               finished = 1;
               break;
            end
            if (fr_col[f] < 0) begin
               if (fr_blk[f]) finished = 1;
               else begin
                  fr_row[f]++;
                  fr_col[f] = fr_row[f];
               end
               continue;
            end
            i = fr_row[f]; c = fr_col[f]; fr_col[f]--;
            ln = 2*c + 1; ld = 2*i - 1;
            rn = 2*c - 1; rd = 2*i + 1;
            if (fr_sn[f] * rd < rn * fr_sd[f]) continue;
            if (ln * fr_ed[f] < fr_en[f] * ld) begin
               fr_col[f] = -1;
               continue;
            end
            ax = ox - c*xx - i*xy;
            ay = oy - c*yx - i*yy;
            if (!on_map(ax, ay)) continue;
            if (c*c + i*i < r*r) light_cell(ax, ay);
            op = !mir_transp[grid_tile[ay*SIDE+ax]];
            if (fr_blk[f]) begin
               if (op) begin
                  fr_nn[f] = rn; fr_nd[f] = rd;
               end else begin
                  fr_blk[f] = 0;
                  fr_sn[f] = fr_nn[f]; fr_sd[f] = fr_nd[f];
               end
            end else if (op) begin
               fr_blk[f] = 1;
               fr_nn[f] = rn; fr_nd[f] = rd;
               if (i + 1 <= r) begin
                  push_scan(i + 1, fr_sn[f], fr_sd[f], ln, ld);
                  spawned = 1;
               end
            end
         end
         if (finished) depth--;
      end
   endtask

   task automatic predict_cell(input cmd_type cmd, output cell_rsp_type res);
      int x, y, r;
      x = int'(cmd.x); y = int'(cmd.y);
      r = (int'(cmd.rad) > RAD_MAX) ? RAD_MAX : int'(cmd.rad);
      case (cmd.op)
         gsv_pkg::OP_WRITE: if (on_map(x, y)) grid_tile[y*SIDE+x] = cmd.tv;
         gsv_pkg::OP_RECOMP: begin
            foreach (grid_vis[k]) grid_vis[k] = 0;
            for (int o = 0; o < 8; o++) cast_octant(x, y, r, o);
         end
         gsv_pkg::OP_FILL: begin
            foreach (grid_tile[k]) begin
               grid_tile[k] = cmd.tv;
               grid_vis[k] = 0;
               grid_seen[k] = 0;
            end
         end
         default: ;
      endcase
      if (on_map(x, y))
         res = '{grid_tile[y*SIDE+x], grid_vis[y*SIDE+x], grid_seen[y*SIDE+x], 1'b1};
      else
         res = '{mir_wall[gsv_pkg::TILE_W-1:0], 1'b0, 1'b0, 1'b0};
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         req.operation <= '0; req.x_coord <= '0; req.y_coord <= '0;
         req.tile_value <= '0; req.view_radius <= '0;
      end else if (!req.valid || req.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 0;
         end else if (pending_cmds.size() != 0) begin
            cmd_type c;
            c = pending_cmds.pop_front();
            req.valid <= 1;
            req.operation <= c.op; req.x_coord <= c.x; req.y_coord <= c.y;
            req.tile_value <= c.tv; req.view_radius <= c.rad;
            send_gap <= pick_gap();
         end else begin
            req.valid <= 0;
         end
      end
   end

   // response stalls
   int hold = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (hold > 0) begin
         hold <= hold - 1;
         rsp.ready <= 0;
      end else begin
         rsp.ready <= 1;
         if (!calm && $urandom_range(0, 99) < 25) hold <= pick_gap();
      end
   end

   // monitor
   int quiet = 0;
   always @(posedge clock) begin
      cell_rsp_type want, got;
      cmd_type c;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.tile_out, rsp.visible_out, rsp.seen_out, rsp.in_bounds};
            if (predicted_rsp.size() == 0) begin
               $display("%0t: unexpected beat, actual %p", $realtime, got);
               errors++;
            end else begin
               want = predicted_rsp.pop_front();
               if (want.tile !== got.tile)
                  $display("%0t: tile_out expected %0d actual %0d", $realtime, want.tile, got.tile);
               if (want.vis !== got.vis)
                  $display("%0t: visible_out expected %0d actual %0d", $realtime, want.vis, got.vis);
               if (want.seen !== got.seen)
                  $display("%0t: seen_out expected %0d actual %0d", $realtime, want.seen, got.seen);
               if (want.inb !== got.inb)
                  $display("%0t: in_bounds expected %0d actual %0d", $realtime, want.inb, got.inb);
               if (want !== got) errors++;
            end
         end
         if (req.valid && req.ready) begin
            c = '{req.operation, req.x_coord, req.y_coord, req.tile_value, req.view_radius};
            predict_cell(c, want);
            predicted_rsp = {predicted_rsp, want};
         end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic add_cmd(logic [gsv_pkg::OP_W-1:0] op, int x, int y, int tv, int rad);
      cmd_type c;
      c.op = op;
      c.x = x[gsv_pkg::COORD_W-1:0];
      c.y = y[gsv_pkg::COORD_W-1:0];
      c.tv = tv[gsv_pkg::TILE_W-1:0];
      c.rad = rad[gsv_pkg::RAD_IN_W-1:0];
      pending_cmds = {pending_cmds, c};
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0 || req.valid || predicted_rsp.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(logic [gsv_pkg::CSR_IDX_W-1:0] idx,
                            logic [gsv_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      case (idx)
         gsv_pkg::CSR_MAP_WIDTH:  mir_width = val[6:0];
         gsv_pkg::CSR_MAP_HEIGHT: mir_height = val[6:0];
         gsv_pkg::CSR_TRANSP:     mir_transp = val;
         gsv_pkg::CSR_WALL:       mir_wall = val[3:0];
         default: ;
      endcase
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // a small room around a viewer: walls, look, then probe nearby cells
   task automatic add_room();
      int ox, oy, n, big;
      ox = $urandom_range(0, map_w() > 0 ? map_w() - 1 : 0);
      oy = $urandom_range(0, map_h() > 0 ? map_h() - 1 : 0);
      n = $urandom_range(3, 10);
      repeat (n) add_cmd(gsv_pkg::OP_WRITE, (ox + $urandom_range(0, 8) - 4) & 7'h7f,
                         (oy + $urandom_range(0, 8) - 4) & 7'h7f, $urandom_range(0, 15),
                         $urandom);
      big = $urandom_range(0, 99);
      add_cmd(gsv_pkg::OP_RECOMP, ox, oy, $urandom,
              big < 8 ? $urandom_range(20, 63) : $urandom_range(0, 9));
      n = $urandom_range(4, 10);
      repeat (n) add_cmd(gsv_pkg::OP_READ, (ox + $urandom_range(0, 12) - 6) & 7'h7f,
                         (oy + $urandom_range(0, 12) - 6) & 7'h7f, $urandom, $urandom);
   endtask

   initial begin
      int p, sent;
      foreach (grid_tile[k]) begin
         grid_tile[k] = 0; grid_vis[k] = 0; grid_seen[k] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed beats on reset settings
      add_cmd(gsv_pkg::OP_READ, 0, 0, 0, 0);
      add_cmd(gsv_pkg::OP_READ, 63, 63, 15, 63);
      add_cmd(gsv_pkg::OP_READ, 64, 0, 0, 0);
      add_cmd(gsv_pkg::OP_READ, 127, 127, 0, 0);
      add_cmd(gsv_pkg::OP_WRITE, 5, 5, 15, 0);
      add_cmd(gsv_pkg::OP_WRITE, 100, 3, 7, 0);
      add_cmd(gsv_pkg::OP_READ, 5, 5, 0, 0);
      add_cmd(gsv_pkg::OP_RECOMP, 5, 5, 0, 0);
      add_cmd(gsv_pkg::OP_READ, 5, 5, 0, 0);
      add_cmd(gsv_pkg::OP_WRITE, 7, 5, 2, 0);
      add_cmd(gsv_pkg::OP_RECOMP, 5, 5, 0, 63);
      add_cmd(gsv_pkg::OP_READ, 6, 5, 0, 0);
      add_cmd(gsv_pkg::OP_READ, 8, 5, 0, 0);
      add_cmd(gsv_pkg::OP_READ, 36, 5, 0, 0);
      add_cmd(gsv_pkg::OP_RECOMP, 70, 10, 0, 10);
      add_cmd(gsv_pkg::OP_READ, 63, 10, 0, 0);
      add_cmd(gsv_pkg::OP_RECOMP, 120, 120, 0, 32);
      add_cmd(gsv_pkg::OP_FILL, 3, 3, 1, 0);
      add_cmd(gsv_pkg::OP_RECOMP, 3, 3, 0, 5);
      add_cmd(gsv_pkg::OP_READ, 4, 3, 0, 0);
      add_cmd(gsv_pkg::OP_FILL, 127, 0, 0, 0);
      add_cmd(gsv_pkg::OP_READ, 10, 10, 0, 0);
      drain();

      sent = 0;
      for (p = 0; sent < 900; p++) begin
         calm = (p % 3 == 2);
         case (p % 6)
            0: begin
               write_reg(gsv_pkg::CSR_MAP_WIDTH, 16'hff81);
               write_reg(gsv_pkg::CSR_MAP_HEIGHT, 16'h0001);
               write_reg(gsv_pkg::CSR_TRANSP, 16'hffff);
               write_reg(gsv_pkg::CSR_WALL, 16'hfff0);
            end
            1: begin
               write_reg(gsv_pkg::CSR_MAP_WIDTH, 16'd0);
               write_reg(gsv_pkg::CSR_MAP_HEIGHT, 16'd64);
               write_reg(gsv_pkg::CSR_TRANSP, 16'd0);
               write_reg(gsv_pkg::CSR_WALL, 16'd15);
            end
            2: begin
               write_reg(gsv_pkg::CSR_MAP_WIDTH, 16'd127);
               write_reg(gsv_pkg::CSR_MAP_HEIGHT, 16'd127);
               write_reg(gsv_pkg::CSR_TRANSP, 16'h00ff);
               write_reg(gsv_pkg::CSR_WALL, 16'd5);
            end
            default: begin
               write_reg(gsv_pkg::CSR_MAP_WIDTH, 16'($urandom_range(1, 70)));
               write_reg(gsv_pkg::CSR_MAP_HEIGHT, 16'($urandom_range(1, 70)));
               write_reg(gsv_pkg::CSR_TRANSP, 16'($urandom));
               write_reg(gsv_pkg::CSR_WALL, 16'($urandom));
            end
         endcase
         if ($urandom_range(0, 1))
            add_cmd(gsv_pkg::OP_FILL, $urandom, $urandom, $urandom_range(0, 15), 0);
         while (pending_cmds.size() < 150) begin
            int k;
            k = $urandom_range(0, 99);
            if (k < 12) add_room();
            else if (k < 13) add_cmd(gsv_pkg::OP_FILL, $urandom, $urandom, $urandom, $urandom);
            else if (k < 14)
               add_cmd(gsv_pkg::OP_RECOMP, $urandom, $urandom, $urandom, $urandom);
            else add_cmd(k < 55 ? gsv_pkg::OP_WRITE : gsv_pkg::OP_READ,
                         $urandom, $urandom, $urandom, $urandom);
         end
         sent += pending_cmds.size();
         drain();
      end

      calm = 0;
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

[grid_shadowcast_visibility_core.f]
+incdir+rtl
rtl/gsv_pkg.sv
rtl/gsv_req_if.sv
rtl/gsv_rsp_if.sv
rtl/grid_shadowcast_visibility_core.sv
test/grid_shadowcast_visibility_core_tb.sv
